@@ design/fdc_pkg.sv @@
// fdc_pkg: types and constants for the floppy controller port model
// no dependencies
`timescale 1ns / 1ps
package fdc_pkg;
    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_CMD  = 2'd1,
        PH_EXEC = 2'd2,
        PH_RES  = 2'd3
    } phase_t;

    localparam logic [7:0] PORT_STATUS  = 8'h90;
    localparam logic [7:0] PORT_FIFO    = 8'h92;
    localparam logic [7:0] PORT_CONTROL = 8'h94;

    localparam logic [4:0] CMD_SPECIFY     = 5'h03;
    localparam logic [4:0] CMD_SENSE_DRIVE = 5'h04;
    localparam logic [4:0] CMD_WRITE_DATA  = 5'h05;
    localparam logic [4:0] CMD_READ_DATA   = 5'h06;
    localparam logic [4:0] CMD_RECAL       = 5'h07;
    localparam logic [4:0] CMD_SENSE_INT   = 5'h08;
    localparam logic [4:0] CMD_READ_ID     = 5'h0A;
    localparam logic [4:0] CMD_FORMAT      = 5'h0D;
    localparam logic [4:0] CMD_SEEK        = 5'h0F;

    localparam logic [1:0] CFG_CYL  = 2'd0;
    localparam logic [1:0] CFG_HEAD = 2'd1;
    localparam logic [1:0] CFG_SPT  = 2'd2;
    localparam logic [1:0] CFG_SIZE = 2'd3;

    localparam logic [7:0] DRIVE_TYPE = 8'h04;
    localparam logic [7:0] NO_RESULT  = 8'hFF;

    typedef struct packed {
        logic [7:0] cylinders;
        logic [1:0] heads;
        logic [7:0] sectors;
        logic [2:0] size_code;
    } geom_t;

    // total command length in bytes per command code, command byte included
    function automatic logic [3:0] cmd_length(input logic [4:0] code);
        case (code)
            CMD_SPECIFY:     cmd_length = 4'd3;
            CMD_SENSE_DRIVE: cmd_length = 4'd2;
            CMD_WRITE_DATA:  cmd_length = 4'd9;
            CMD_READ_DATA:   cmd_length = 4'd9;
            CMD_RECAL:       cmd_length = 4'd2;
            CMD_SENSE_INT:   cmd_length = 4'd1;
            CMD_READ_ID:     cmd_length = 4'd2;
            CMD_FORMAT:      cmd_length = 4'd6;
            CMD_SEEK:        cmd_length = 4'd3;
            default:         cmd_length = 4'd1;
        endcase
    endfunction

    function automatic logic [7:0] msr_value(input phase_t ph);
        case (ph)
            PH_IDLE: msr_value = 8'h80;
            PH_CMD:  msr_value = 8'h90;
            PH_EXEC: msr_value = 8'h10;
            default: msr_value = 8'hD0;
        endcase
    endfunction
endpackage

@@ design/fdc_cfg.sv @@
// fdc_cfg: geometry configuration registers
// depends on fdc_pkg
`timescale 1ns / 1ps
module fdc_cfg (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          cfg_valid,
    input  logic [1:0]    cfg_index,
    input  logic          cfg_index_hi,
    input  logic [7:0]    cfg_data,
    output fdc_pkg::geom_t geom
);
    import fdc_pkg::*;
    geom_t geom_reg;
    assign geom = geom_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            geom_reg <= '{cylinders: 8'd77, heads: 2'd2, sectors: 8'd8, size_code: 3'd3};
        end else if (cfg_valid && !cfg_index_hi) begin
            unique case (cfg_index)
                CFG_CYL:  geom_reg.cylinders <= cfg_data;
                CFG_HEAD: geom_reg.heads     <= cfg_data[1:0];
                CFG_SPT:  geom_reg.sectors   <= cfg_data;
                CFG_SIZE: geom_reg.size_code <= cfg_data[2:0];
                default: ;
            endcase
        end
    end
endmodule

@@ design/fdc_core.sv @@
// fdc_core: command/result machine, one port request per cycle while req_en is high
// depends on fdc_pkg
`timescale 1ns / 1ps
module fdc_core #(
    parameter int COMMAND_DEPTH = 9,
    parameter int RESULT_DEPTH  = 7
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           req_en,
    input  logic           req_type,
    input  logic [7:0]     port_addr,
    input  logic [7:0]     write_data,
    input  fdc_pkg::geom_t geom,
    output logic [7:0]     rd_data,
    output logic           rd_hit
);
    import fdc_pkg::*;
    localparam int CW = $clog2(COMMAND_DEPTH + 1);

    phase_t     phase_reg, phase_next;
    logic [7:0] cmd_byte_reg, cmd_byte_next;
    logic [7:0] cbuf_reg [COMMAND_DEPTH];
    logic [7:0] cbuf_next [COMMAND_DEPTH];
    logic [CW-1:0] ccount_reg, ccount_next;
    logic [3:0] clen_reg, clen_next;
    logic [7:0] rbuf_reg [RESULT_DEPTH];
    logic [7:0] rbuf_next [RESULT_DEPTH];
    logic [2:0] ridx_reg, ridx_next;
    logic [2:0] rlen_reg, rlen_next;
    logic [7:0] st0_reg, st0_next;
    logic [7:0] pcn_reg, pcn_next;
    logic [1:0] drv_reg, drv_next;
    logic       head_reg, head_next;
    logic [7:0] ctrl_reg, ctrl_next;
    logic [2:0] intp_reg, intp_next;

    logic [7:0] p1, p2, p3, p4, p5, code_byte, st_new, sm1;
    logic       run, rw_bad;

    always_comb begin
        phase_next = phase_reg; cmd_byte_next = cmd_byte_reg; cbuf_next = cbuf_reg;
        ccount_next = ccount_reg; clen_next = clen_reg; rbuf_next = rbuf_reg;
        ridx_next = ridx_reg; rlen_next = rlen_reg; st0_next = st0_reg;
        pcn_next = pcn_reg; drv_next = drv_reg; head_next = head_reg;
        ctrl_next = ctrl_reg; intp_next = intp_reg;
        rd_data = 8'h00; rd_hit = 1'b1; run = 1'b0;
        code_byte = cmd_byte_reg;
        if (port_addr == PORT_STATUS) begin
            if (!req_type) rd_data = msr_value(phase_reg);
        end else if (port_addr == PORT_FIFO) begin
            if (req_type) begin
                if (phase_reg == PH_IDLE || phase_reg == PH_RES) begin
                    cmd_byte_next = write_data;
                    code_byte = write_data;
                    cbuf_next[0] = write_data;
                    ccount_next = CW'(1);
                    clen_next = cmd_length(write_data[4:0]);
                    if (cmd_length(write_data[4:0]) == 4'd1) run = 1'b1;
                    else phase_next = PH_CMD;
                end else if (phase_reg == PH_CMD) begin
                    if (ccount_reg < CW'(COMMAND_DEPTH)) begin
                        for (int i = 0; i < COMMAND_DEPTH; i++)
                            if (ccount_reg == CW'(i)) cbuf_next[i] = write_data;
                        ccount_next = ccount_reg + CW'(1);
                    end
                    if ({{(8-CW){1'b0}}, ccount_next} >= {4'd0, clen_reg}) run = 1'b1;
                end
            end else begin
                if (phase_reg == PH_RES && ridx_reg < rlen_reg &&
                    {5'd0, ridx_reg} < 8'(RESULT_DEPTH)) begin
                    rd_data = rbuf_reg[ridx_reg];
                    ridx_next = ridx_reg + 3'd1;
                    if (ridx_next >= rlen_reg) phase_next = PH_IDLE;
                end else begin
                    rd_data = NO_RESULT;
                end
            end
        end else if (port_addr == PORT_CONTROL) begin
            if (req_type) begin
                ctrl_next = write_data;
                if (ctrl_reg[7] && !write_data[7]) begin
                    phase_next = PH_IDLE; ccount_next = '0; ridx_next = 3'd0;
                    rlen_next = 3'd0; st0_next = 8'hC0; intp_next = 3'd4;
                end
            end else begin
                rd_data = DRIVE_TYPE;
            end
        end else begin
            rd_hit = 1'b0;
        end

        p1 = cbuf_next[1]; p2 = cbuf_next[2]; p3 = cbuf_next[3];
        p4 = cbuf_next[4]; p5 = cbuf_next[5];
        sm1 = p4 - 8'd1;
        rw_bad = (p5 != {5'd0, geom.size_code}) || (p4 == 8'd0) ||
                 (p2 >= geom.cylinders) || ({1'b0, p3[0]} >= geom.heads) ||
                 (sm1 >= geom.sectors);
        st_new = {5'd0, p1[2], drv_reg};
        if (run) begin
            ridx_next = 3'd0;
            rlen_next = 3'd0;
            case (code_byte[4:0])
                CMD_SPECIFY: ;
                CMD_SENSE_DRIVE: begin
                    rbuf_next[0] = {2'b00, 1'b1, (pcn_reg == 8'd0), 1'b0, p1[2:0]};
                    rlen_next = 3'd1;
                end
                CMD_WRITE_DATA, CMD_READ_DATA: begin
                    rlen_next = 3'd7;
                    if (rw_bad) begin
                        rbuf_next[0] = {2'b01, st0_reg[5:0]};
                        rbuf_next[1] = 8'h04; rbuf_next[2] = 8'h00;
                        rbuf_next[3] = pcn_reg; rbuf_next[4] = {7'd0, head_reg};
                        rbuf_next[5] = 8'h01; rbuf_next[6] = 8'h00;
                    end else begin
                        st0_next = st_new;
                        rbuf_next[0] = st_new; rbuf_next[1] = 8'h00; rbuf_next[2] = 8'h00;
                        rbuf_next[3] = p2; rbuf_next[4] = {7'd0, p3[0]};
                        rbuf_next[5] = p4 + 8'd1; rbuf_next[6] = p5;
                    end
                end
                CMD_RECAL: begin
                    pcn_next = 8'd0; drv_next = p1[1:0];
                    st0_next = {6'b001000, p1[1:0]}; intp_next = 3'd1;
                end
                CMD_SENSE_INT: begin
                    if (intp_reg != 3'd0) intp_next = intp_reg - 3'd1;
                    else st0_next = 8'h80;
                    rbuf_next[0] = (intp_reg != 3'd0) ? st0_reg : 8'h80;
                    rbuf_next[1] = pcn_reg;
                    rlen_next = 3'd2;
                end
                CMD_READ_ID, CMD_FORMAT: begin
                    st0_next = st_new;
                    rbuf_next[0] = st_new; rbuf_next[1] = 8'h00; rbuf_next[2] = 8'h00;
                    rbuf_next[3] = pcn_reg; rbuf_next[4] = {7'd0, p1[0]};
                    rbuf_next[5] = 8'h01;
                    rbuf_next[6] = (code_byte[4:0] == CMD_READ_ID) ?
                                   {5'd0, geom.size_code} : p2;
                    rlen_next = 3'd7;
                end
                CMD_SEEK: begin
                    drv_next = p1[1:0]; head_next = p1[2]; pcn_next = p2;
                    st0_next = {5'b00100, p1[2], p1[1:0]}; intp_next = 3'd1;
                end
                default: begin
                    rbuf_next[0] = 8'h80;
                    rlen_next = 3'd1;
                end
            endcase
            phase_next = (rlen_next != 3'd0) ? PH_RES : PH_IDLE;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE; cmd_byte_reg <= '0; ccount_reg <= '0; clen_reg <= '0;
            ridx_reg <= '0; rlen_reg <= '0; st0_reg <= '0; pcn_reg <= '0;
            drv_reg <= '0; head_reg <= 1'b0; ctrl_reg <= '0; intp_reg <= '0;
            for (int i = 0; i < COMMAND_DEPTH; i++) cbuf_reg[i] <= '0;
            for (int i = 0; i < RESULT_DEPTH; i++) rbuf_reg[i] <= '0;
        end else if (req_en) begin
            phase_reg <= phase_next; cmd_byte_reg <= cmd_byte_next;
            ccount_reg <= ccount_next; clen_reg <= clen_next;
            ridx_reg <= ridx_next; rlen_reg <= rlen_next; st0_reg <= st0_next;
            pcn_reg <= pcn_next; drv_reg <= drv_next; head_reg <= head_next;
            ctrl_reg <= ctrl_next; intp_reg <= intp_next;
            cbuf_reg <= cbuf_next; rbuf_reg <= rbuf_next;
        end
    end
endmodule

@@ design/floppy_controller_port_model.sv @@
// floppy_controller_port_model: top level, port request in, read byte out
// depends on fdc_pkg, fdc_cfg, fdc_core
//
//  channel | valid     | ready     | payload
//  s_      | s_valid   | s_ready   | s_req_type, s_port_addr, s_write_data
//  m_      | m_valid   | m_ready   | m_read_data, m_handled
//  cfg     | cfg_valid | cfg_ready | cfg_index, cfg_data
//
// one request per cycle while s_ready is high; the controller state updates at acceptance and the
// response sits in a single output register from the next cycle
// s_ready is high whenever the output register is empty or being taken
// aresetn is synchronous, active low; geometry returns to its defaults
`timescale 1ns / 1ps
module floppy_controller_port_model #(
    parameter int COMMAND_DEPTH = 9,
    parameter int RESULT_DEPTH  = 7
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic       s_req_type,
    input  logic [7:0] s_port_addr,
    input  logic [7:0] s_write_data,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_read_data,
    output logic       m_handled,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [7:0] cfg_index,
    input  logic [7:0] cfg_data
);
    import fdc_pkg::*;
    geom_t      geom;
    logic       acc;
    logic [7:0] rd;
    logic       hit;
    logic       m_valid_reg;
    logic [7:0] rd_reg;
    logic       hit_reg;

    assign cfg_ready = 1'b1;
    assign s_ready = !m_valid_reg || m_ready;
    assign acc = s_valid && s_ready;

    fdc_cfg u_cfg (
        .aclk(aclk), .aresetn(aresetn), .cfg_valid(cfg_valid),
        .cfg_index(cfg_index[1:0]), .cfg_index_hi(|cfg_index[7:2]),
        .cfg_data(cfg_data), .geom(geom)
    );

    fdc_core #(.COMMAND_DEPTH(COMMAND_DEPTH), .RESULT_DEPTH(RESULT_DEPTH)) u_core (
        .aclk(aclk), .aresetn(aresetn), .req_en(acc), .req_type(s_req_type),
        .port_addr(s_port_addr), .write_data(s_write_data), .geom(geom),
        .rd_data(rd), .rd_hit(hit)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_ready) begin
            m_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (acc) begin
            rd_reg  <= rd;
            hit_reg <= hit;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_read_data = rd_reg;
    assign m_handled   = hit_reg;
endmodule

@@ design/fdc_checker.sv @@
// fdc_checker: port-level assertions for the floppy controller port model
// depends on fdc_pkg and floppy_controller_port_model ports; bound below
`timescale 1ns / 1ps
module fdc_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_valid,
    input logic       s_ready,
    input logic [7:0] s_port_addr,
    input logic       m_valid,
    input logic       m_ready,
    input logic [7:0] m_read_data,
    input logic       m_handled
);
    import fdc_pkg::*;
    a_resp_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> m_valid) else $error("request without response");
    a_ready_free: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready) else $error("stalled with empty output");
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_read_data))
        else $error("response changed under stall");
    a_unhandled: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_port_addr != PORT_STATUS && s_port_addr != PORT_FIFO &&
        s_port_addr != PORT_CONTROL |=> !m_handled && m_read_data == 8'h00)
        else $error("unhandled port answered");
endmodule

bind floppy_controller_port_model fdc_checker u_fdc_checker (
    .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
    .s_port_addr(s_port_addr), .m_valid(m_valid), .m_ready(m_ready),
    .m_read_data(m_read_data), .m_handled(m_handled)
);

@@ tb/floppy_controller_port_model_tb.sv @@
// floppy_controller_port_model_tb: checks port requests against a behavioral
// controller model (phases, commands, geometry checks, control reset)
// depends on fdc_pkg and floppy_controller_port_model
`timescale 1ns / 1ps
module floppy_controller_port_model_tb;
    import fdc_pkg::*;

    typedef struct {
        logic       wr;
        logic [7:0] port;
        logic [7:0] data;
    } port_req_t;

    typedef struct {
        logic [7:0] rdata;
        logic       hit;
    } port_rsp_t;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic       s_req_type = 1'b0;
    logic [7:0] s_port_addr = 8'h00;
    logic [7:0] s_write_data = 8'h00;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic [7:0] m_read_data;
    logic       m_handled;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [7:0] cfg_index = 8'h00;
    logic [7:0] cfg_data = 8'h00;

    floppy_controller_port_model dut (.*);

    always #1 aclk = ~aclk;

    port_req_t req_queue[$];
    port_rsp_t rsp_queue[$];
    int        errors = 0;
    int        n_checked = 0;
    int        n_cmds = 0;
    bit        calm = 0;
    bit        s_taken = 0;
    int        hold_cycles = 0;

    // model state
    logic [7:0] g_cyl, g_spt;
    logic [1:0] g_heads;
    logic [2:0] g_size;
    phase_t     m_phase;
    logic [7:0] m_cmd;
    logic [7:0] m_cbuf[9];
    logic [3:0] m_ccount, m_clen;
    logic [7:0] m_rbuf[7];
    logic [2:0] m_ridx, m_rlen;
    logic [7:0] m_st0, m_pcn, m_ctrl;
    logic [1:0] m_drv;
    logic       m_head;
    logic [2:0] m_ipend;

    function automatic logic [3:0] code_len(logic [4:0] c);
        case (c)
            CMD_SPECIFY: return 3;
            CMD_SENSE_DRIVE, CMD_RECAL, CMD_READ_ID: return 2;
            CMD_WRITE_DATA, CMD_READ_DATA: return 9;
            CMD_FORMAT: return 6;
            CMD_SEEK: return 3;
            default: return 1;
        endcase
    endfunction

    function automatic void load_ok(logic [7:0] c, logic [7:0] h, logic [7:0] r,
                                    logic [7:0] n);
        m_rbuf[0] = m_st0; m_rbuf[1] = 0; m_rbuf[2] = 0;
        m_rbuf[3] = c; m_rbuf[4] = h; m_rbuf[5] = r; m_rbuf[6] = n;
        m_rlen = 7;
    endfunction

    function automatic void execute_command();
        logic [7:0] hdus, sect, rm1;
        hdus = m_cbuf[1];
        m_ridx = 0;
        m_rlen = 0;
        case (m_cmd[4:0])
            CMD_SPECIFY: ;
            CMD_SENSE_DRIVE: begin
                m_rbuf[0] = {3'b001, m_pcn == 0, 1'b0, hdus[2:0]};
                m_rlen = 1;
            end
            CMD_WRITE_DATA, CMD_READ_DATA: begin
                sect = m_cbuf[4];
                rm1 = sect - 8'd1;
                if (m_cbuf[5] != {5'd0, g_size} || sect == 0 || m_cbuf[2] >= g_cyl ||
                    {1'b0, m_cbuf[3][0]} >= g_heads || rm1 >= g_spt) begin
                    m_rbuf[0] = (m_st0 & 8'h3F) | 8'h40; m_rbuf[1] = 8'h04; m_rbuf[2] = 0;
                    m_rbuf[3] = m_pcn; m_rbuf[4] = {7'd0, m_head}; m_rbuf[5] = 1;
                    m_rbuf[6] = 0; m_rlen = 7;
                end else begin
                    m_st0 = {5'd0, hdus[2], m_drv};
                    load_ok(m_cbuf[2], {7'd0, m_cbuf[3][0]}, sect + 8'd1, m_cbuf[5]);
                end
            end
            CMD_RECAL: begin
                m_pcn = 0; m_drv = hdus[1:0]; m_st0 = {6'b001000, m_drv}; m_ipend = 1;
            end
            CMD_SENSE_INT: begin
                if (m_ipend != 0) m_ipend = m_ipend - 1;
                else m_st0 = 8'h80;
                m_rbuf[0] = m_st0; m_rbuf[1] = m_pcn; m_rlen = 2;
            end
            CMD_READ_ID: begin
                m_st0 = {5'd0, hdus[2], m_drv};
                load_ok(m_pcn, {7'd0, hdus[0]}, 1, {5'd0, g_size});
            end
            CMD_FORMAT: begin
                m_st0 = {5'd0, hdus[2], m_drv};
                load_ok(m_pcn, {7'd0, hdus[0]}, 1, m_cbuf[2]);
            end
            CMD_SEEK: begin
                m_drv = hdus[1:0]; m_head = hdus[2]; m_pcn = m_cbuf[2];
                m_st0 = {5'b00100, m_head, m_drv}; m_ipend = 1;
            end
            default: begin
                m_rbuf[0] = 8'h80; m_rlen = 1;
            end
        endcase
        m_phase = (m_rlen > 0) ? PH_RES : PH_IDLE;
    endfunction

    function automatic port_rsp_t predict_access(port_req_t q);
        port_rsp_t r;
        r.rdata = 0;
        r.hit = 1;
        if (q.port == PORT_STATUS) begin
            if (!q.wr)
                case (m_phase)
                    PH_IDLE: r.rdata = 8'h80;
                    PH_CMD:  r.rdata = 8'h90;
                    PH_EXEC: r.rdata = 8'h10;
                    default: r.rdata = 8'hD0;
                endcase
        end else if (q.port == PORT_FIFO) begin
            if (q.wr) begin
                if (m_phase == PH_IDLE || m_phase == PH_RES) begin
                    m_cmd = q.data; m_cbuf[0] = q.data; m_ccount = 1;
                    m_clen = code_len(q.data[4:0]);
                    if (m_clen == 1) execute_command();
                    else m_phase = PH_CMD;
                end else if (m_phase == PH_CMD) begin
                    if (m_ccount < 9) begin
                        m_cbuf[m_ccount] = q.data; m_ccount++;
                    end
                    if (m_ccount >= m_clen) execute_command();
                end
            end else if (m_phase == PH_RES && m_ridx < m_rlen) begin
                r.rdata = m_rbuf[m_ridx];
                m_ridx++;
                if (m_ridx >= m_rlen) m_phase = PH_IDLE;
            end else
                r.rdata = NO_RESULT;
        end else if (q.port == PORT_CONTROL) begin
            if (q.wr) begin
                if (m_ctrl[7] && !q.data[7]) begin
                    m_phase = PH_IDLE; m_ccount = 0; m_ridx = 0; m_rlen = 0;
                    m_st0 = 8'hC0; m_ipend = 4;
                end
                m_ctrl = q.data;
            end else
                r.rdata = DRIVE_TYPE;
        end else
            r.hit = 0;
        return r;
    endfunction

    // driver
    always @(negedge aclk) begin
        if (aresetn) begin
            if (!s_valid || s_taken) begin
                if (req_queue.size() > 0 && (calm || $urandom_range(0, 99) >= 13)) begin
                    s_valid <= 1'b1;
                    s_req_type <= req_queue[0].wr;
                    s_port_addr <= req_queue[0].port;
                    s_write_data <= req_queue[0].data;
                    void'(req_queue.pop_front());
                end else
                    s_valid <= 1'b0;
            end
            if (hold_cycles > 0) begin
                m_ready <= 1'b0;
                hold_cycles <= hold_cycles - 1;
            end else
                m_ready <= calm || $urandom_range(0, 99) >= 13;
        end
    end

    // monitor
    always @(posedge aclk) begin
        port_rsp_t e;
        s_taken = 1'b0;
        if (aresetn && m_valid && m_ready) begin
            if (rsp_queue.size() == 0) begin
                $error("response with nothing expected");
                errors++;
            end else begin
                e = rsp_queue.pop_front();
                n_checked++;
                if (m_read_data !== e.rdata) begin
                    $error("read_data expected %h actual %h", e.rdata, m_read_data);
                    errors++;
                end
                if (m_handled !== e.hit) begin
                    $error("handled expected %h actual %h", e.hit, m_handled);
                    errors++;
                end
            end
        end
        if (aresetn && s_valid && s_ready) begin
            rsp_queue.push_back(predict_access('{s_req_type, s_port_addr, s_write_data}));
            s_taken = 1'b1;
        end
    end

    task automatic add_req(logic wr, logic [7:0] port, logic [7:0] data);
        req_queue.push_back('{wr, port, data});
    endtask

    task automatic add_cmd(logic [7:0] code);
        int len;
        len = code_len(code[4:0]);
        add_req(1, PORT_FIFO, code);
        for (int i = 1; i < len; i++) add_req(1, PORT_FIFO, 8'($urandom));
        for (int i = 0; i < 8; i++) add_req(0, PORT_FIFO, 0);
        n_cmds++;
    endtask

    task automatic add_rw(logic [7:0] code, bit good);
        logic [7:0] c, s, h;
        c = 8'($urandom_range(0, g_cyl - 1));
        h = {7'($urandom), 1'($urandom_range(0, g_heads - 1))};
        s = 8'($urandom_range(1, g_spt));
        add_req(1, PORT_FIFO, code);
        add_req(1, PORT_FIFO, 8'($urandom));
        add_req(1, PORT_FIFO, good ? c : 8'($urandom));
        add_req(1, PORT_FIFO, good ? h : 8'($urandom));
        add_req(1, PORT_FIFO, good ? s : 8'($urandom));
        add_req(1, PORT_FIFO, good ? {5'd0, g_size} : 8'($urandom_range(0, 8)));
        for (int i = 0; i < 3; i++) add_req(1, PORT_FIFO, 8'($urandom));
        add_req(0, PORT_STATUS, 8'($urandom));
        for (int i = 0; i < 7; i++) add_req(0, PORT_FIFO, 8'($urandom));
        n_cmds++;
    endtask

    task automatic wait_drained();
        while (req_queue.size() > 0 || rsp_queue.size() > 0 || s_valid) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_geom(logic [7:0] c, logic [1:0] h, logic [7:0] s, logic [2:0] n);
        logic [7:0] vals[4];
        vals = '{c, {6'd0, h}, s, {5'd0, n}};
        for (int i = 0; i < 4; i++) begin
            @(negedge aclk);
            cfg_valid <= 1'b1;
            cfg_index <= 8'(i);
            cfg_data <= vals[i];
            @(posedge aclk);
            while (!cfg_ready) @(posedge aclk);
            @(negedge aclk);
            cfg_valid <= 1'b0;
        end
        g_cyl = c; g_heads = h; g_size = n; g_spt = s;
    endtask

    task automatic add_random_burst(int count);
        int k;
        logic [7:0] codes[10];
        codes = '{8'h03, 8'h04, 8'h05, 8'h06, 8'h07, 8'h08, 8'h0A, 8'h0D, 8'h0F, 8'h00};
        for (int i = 0; i < count; i++) begin
            k = $urandom_range(0, 99);
            if (k < 35) add_rw({3'($urandom), codes[$urandom_range(2, 3)][4:0]}, k < 25);
            else if (k < 65) add_cmd({3'($urandom), codes[$urandom_range(0, 9)][4:0]});
            else if (k < 70) add_cmd(8'($urandom));
            else if (k < 75) begin
                add_req(1, PORT_CONTROL, 8'h80 | 8'($urandom));
                add_req(1, PORT_CONTROL, 8'($urandom) & 8'h7F);
                add_req(0, PORT_CONTROL, 0);
                add_cmd({3'($urandom), CMD_SENSE_INT});
            end else
                add_req(1'($urandom), $urandom_range(0, 3) == 0 ? 8'($urandom) :
                        8'h90 + 8'(2 * $urandom_range(0, 2)), 8'($urandom));
        end
    endtask

    initial begin
        g_cyl = 77; g_heads = 2; g_spt = 8; g_size = 3;
        m_phase = PH_IDLE; m_cmd = 0; m_ccount = 0; m_clen = 0; m_ridx = 0; m_rlen = 0;
        m_st0 = 0; m_pcn = 0; m_ctrl = 0; m_drv = 0; m_head = 0; m_ipend = 0;
        foreach (m_cbuf[i]) m_cbuf[i] = 0;
        foreach (m_rbuf[i]) m_rbuf[i] = 0;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed: every port, every command, geometry checks, control reset
        add_req(0, PORT_STATUS, 0); add_req(1, PORT_STATUS, 8'hFF);
        add_req(0, PORT_FIFO, 0); add_req(0, PORT_CONTROL, 0);
        add_req(0, 8'h00, 8'h00); add_req(1, 8'hFF, 8'hFF);
        add_cmd(CMD_SENSE_INT); add_cmd(CMD_SEEK); add_cmd(CMD_SENSE_INT);
        add_rw(CMD_READ_DATA, 1); add_rw(CMD_WRITE_DATA, 0);
        add_cmd(CMD_READ_ID); add_cmd(CMD_FORMAT); add_cmd(CMD_RECAL);
        add_cmd(CMD_SENSE_DRIVE); add_cmd(CMD_SPECIFY); add_cmd(8'hFF);
        add_req(1, PORT_FIFO, CMD_SEEK); add_req(1, PORT_FIFO, 0);
        add_req(1, PORT_CONTROL, 8'h80); add_req(1, PORT_CONTROL, 8'h00);
        add_cmd(CMD_SENSE_INT);
        wait_drained();

        write_geom(8'd1, 2'd1, 8'd1, 3'd0);
        add_rw(CMD_READ_DATA, 1); add_rw(CMD_READ_DATA, 0);
        add_random_burst(10);
        wait_drained();

        write_geom(8'd255, 2'd2, 8'd255, 3'd7);
        add_rw(CMD_WRITE_DATA, 1);
        add_random_burst(8);
        hold_cycles = 60;
        wait_drained();

        write_geom(8'd77, 2'd2, 8'd8, 3'd3);
        calm = 1;
        add_random_burst(8);
        wait_drained();
        calm = 0;

        write_geom(8'($urandom_range(1, 255)), 2'($urandom_range(1, 2)),
                   8'($urandom_range(1, 255)), 3'($urandom));
        add_random_burst(8);
        wait_drained();

        repeat (10) @(posedge aclk);
        $display("checked %0d responses over %0d commands and five geometry settings",
                 n_checked, n_cmds);
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial begin
        #2000000;
        $display("FAILURE");
        $finish;
    end
endmodule

@@ files.f @@
design/fdc_pkg.sv
design/fdc_cfg.sv
design/fdc_core.sv
design/floppy_controller_port_model.sv
design/fdc_checker.sv
tb/floppy_controller_port_model_tb.sv
